@@ rtl/mat_pkg.sv @@
`timescale 1ns / 1ps
package mat_pkg;

	localparam int NUM_READINGS = 8;
	localparam int IDX_W        = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
	localparam int SUM_W        = $clog2(NUM_READINGS * 255 + 1);
	localparam int LEVEL_W      = 8;
	localparam int DUR_W        = 16;
	localparam int CFG_IDX_W    = 8;

	localparam logic [LEVEL_W-1:0] READING_INIT = 8'd100;
	localparam logic [SUM_W-1:0]   SUM_INIT     = SUM_W'(100 * NUM_READINGS);
	localparam logic [IDX_W-1:0]   IDX_LAST     = IDX_W'(NUM_READINGS - 1);

	localparam logic [LEVEL_W-1:0] THRESH_RESET = 8'd30;
	localparam logic [DUR_W-1:0]   DUR_RESET    = 16'd60;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_THRESHOLD = 8'd0,
		REG_ON_DURATION   = 8'd1
	} reg_idx_t;

	// Read and write request from the update logic to the ring memory.
	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		logic [LEVEL_W-1:0] wr_data;
	} ring_req_t;

endpackage

@@ rtl/mat_ring.sv @@
`timescale 1ns / 1ps
module mat_ring (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mat_pkg::ring_req_t         req,
	output logic [mat_pkg::LEVEL_W-1:0] rd_data
);
	import mat_pkg::*;

	logic [LEVEL_W-1:0]      mem [NUM_READINGS];
	logic [NUM_READINGS-1:0] valid_q;
	logic [LEVEL_W-1:0]      mem_rd_q;
	logic                    rd_valid_q;
	logic                    fwd_hit_q;
	logic [LEVEL_W-1:0]      fwd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q   <= mem[req.rd_addr];
			fwd_data_q <= req.wr_data;
		end
	end

	// A read and a write of the same entry at one edge return the new value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
				fwd_hit_q  <= req.wr_en && (req.wr_addr == req.rd_addr);
			end
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (rd_valid_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = READING_INIT;
		end
	end

endmodule

@@ rtl/mat_core.sv @@
`timescale 1ns / 1ps
module mat_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  logic                        in_op,
	input  logic [mat_pkg::LEVEL_W-1:0] in_level,
	input  logic                        advance,
	input  logic [mat_pkg::LEVEL_W-1:0] min_threshold,
	input  logic [mat_pkg::DUR_W-1:0]   on_duration_ticks,
	input  logic [mat_pkg::LEVEL_W-1:0] rd_data,
	output mat_pkg::ring_req_t          req,
	output logic                        busy,
	output logic                        commit,
	output logic                        res_lamp,
	output logic [mat_pkg::LEVEL_W-1:0] res_avg
);
	import mat_pkg::*;

	logic               valid_s1;
	op_t                op_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [SUM_W-1:0]   sum_q;
	logic [IDX_W-1:0]   widx_q;
	logic [DUR_W-1:0]   countdown_q;
	logic               lamp_q;

	logic [SUM_W-1:0]   sum_new;
	logic [SUM_W-1:0]   sum_next;
	logic [IDX_W-1:0]   widx_inc;
	logic [LEVEL_W-1:0] avg;
	logic [DUR_W-1:0]   countdown_next;
	logic [DUR_W-1:0]   reload;
	logic               lamp_next;

	assign busy   = valid_s1;
	assign commit = valid_s1 && advance;

	assign widx_inc = (widx_q == IDX_LAST) ? '0 : widx_q + 1'b1;
	assign reload   = (on_duration_ticks == '0) ? DUR_W'(1) : on_duration_ticks;

	// The stored sum never goes below the entry it loses, so no borrow occurs.
	assign sum_new = sum_q - SUM_W'(rd_data) + SUM_W'(level_s1);

	always_comb begin
		sum_next       = sum_q;
		countdown_next = countdown_q;
		lamp_next      = lamp_q;
		if (op_s1 == OP_SAMPLE) begin
			sum_next = sum_new;
		end
		avg = LEVEL_W'(sum_next / NUM_READINGS);
		case (op_s1)
			OP_SAMPLE: begin
				if (avg < min_threshold) begin
					lamp_next      = 1'b1;
					countdown_next = reload;
				end
			end
			OP_TICK: begin
				if (countdown_q != '0) begin
					countdown_next = countdown_q - 1'b1;
					if (countdown_q == DUR_W'(1)) begin
						lamp_next = 1'b0;
					end
				end
			end
			default: begin
				lamp_next = lamp_q;
			end
		endcase
	end

	assign res_lamp = lamp_next;
	assign res_avg  = avg;

	always_comb begin
		req.rd_en   = in_accept && (op_t'(in_op) == OP_SAMPLE);
		req.rd_addr = widx_q;
		req.wr_en   = commit && (op_s1 == OP_SAMPLE);
		req.wr_addr = idx_s1;
		req.wr_data = level_s1;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= op_t'(in_op);
			level_s1 <= in_level;
			idx_s1   <= widx_q;
		end
	end

	// The write index moves at acceptance so that the next sample reads its own entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			widx_q      <= '0;
			sum_q       <= SUM_INIT;
			countdown_q <= '0;
			lamp_q      <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (in_accept && (op_t'(in_op) == OP_SAMPLE)) begin
				widx_q <= widx_inc;
			end
			if (commit) begin
				sum_q       <= sum_next;
				countdown_q <= countdown_next;
				lamp_q      <= lamp_next;
			end
		end
	end

	a_lamp_matches_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		lamp_q == (countdown_q != '0))
		else $error("lamp state disagrees with countdown");

	a_sum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(NUM_READINGS * 255))
		else $error("running sum beyond the largest ring total");

	a_tick_keeps_sum: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (op_s1 == OP_TICK) |=> $stable(sum_q))
		else $error("tick changed the running sum");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en && req.rd_en && (NUM_READINGS > 1) |-> req.wr_addr != req.rd_addr)
		else $error("back-to-back samples address the same ring entry");

endmodule

@@ rtl/moving_average_light_trigger.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: sample_level; tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: lamp_on, average_level
// cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One beat per cycle while the output is not stalled; an accepted beat passes through the update
// stage and then the result register, which drives m_axis.
// The reading ring is read the cycle a sample is accepted and written when that sample
// leaves the update stage.
// After reset the ring reads as 100 in every entry, with no clearing pass.
// A stalled output holds the result register and the update stage, and s_axis_tready
// drops once the update stage holds a beat.
// Configuration writes are always taken.
module moving_average_light_trigger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] sample_level
	input  logic [0:0]  s_axis_tuser,  // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [0] lamp_on, [8:1] average_level, [15:9] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mat_pkg::*;

	logic               in_accept;
	logic               advance;
	logic               busy;
	logic               commit;
	logic               res_lamp;
	logic [LEVEL_W-1:0] res_avg;
	logic [LEVEL_W-1:0] rd_data;
	ring_req_t          req;

	logic [LEVEL_W-1:0] min_threshold_q;
	logic [DUR_W-1:0]   on_duration_q;
	logic               out_valid_q;
	logic               out_lamp_q;
	logic [LEVEL_W-1:0] out_avg_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !busy || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	mat_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	mat_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_accept         (in_accept),
		.in_op             (s_axis_tuser[0]),
		.in_level          (s_axis_tdata),
		.advance           (advance),
		.min_threshold     (min_threshold_q),
		.on_duration_ticks (on_duration_q),
		.rd_data           (rd_data),
		.req               (req),
		.busy              (busy),
		.commit            (commit),
		.res_lamp          (res_lamp),
		.res_avg           (res_avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_threshold_q <= THRESH_RESET;
			on_duration_q   <= DUR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_THRESHOLD: min_threshold_q <= cfg_data[LEVEL_W-1:0];
				REG_ON_DURATION:   on_duration_q   <= cfg_data;
				default: begin
					on_duration_q <= on_duration_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_lamp_q <= res_lamp;
			out_avg_q  <= res_avg;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_avg_q, out_lamp_q};

	a_no_commit_into_full: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || m_axis_tready))
		else $error("result written over one not yet taken");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> busy)
		else $error("accepted beat did not reach the update stage");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !advance |-> !s_axis_tready)
		else $error("input taken while the update stage is stalled");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import mat_pkg::*;

	typedef struct packed {
		logic               lamp;
		logic [LEVEL_W-1:0] average;
	} lamp_status_t;

	// Tracks the ring of readings, the lamp and its countdown, and holds the
	// status beats the block still owes.
	class lamp_scoreboard;
		logic [LEVEL_W-1:0] ring[NUM_READINGS];
		logic [IDX_W-1:0]   wr_ptr;
		logic [SUM_W-1:0]   level_sum;
		logic [DUR_W-1:0]   hold_count;
		logic               lamp;
		logic [LEVEL_W-1:0] thresh;
		logic [DUR_W-1:0]   on_ticks;
		lamp_status_t       status_q[$];
		int                 mismatches;

		function new();
			foreach (ring[i]) ring[i] = READING_INIT;
			wr_ptr     = '0;
			level_sum  = SUM_INIT;
			hold_count = '0;
			lamp       = 1'b0;
			thresh     = THRESH_RESET;
			on_ticks   = DUR_RESET;
			mismatches = 0;
		endfunction

		function void fail(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s", $realtime, msg);
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_MIN_THRESHOLD: thresh = data[LEVEL_W-1:0];
				REG_ON_DURATION:   on_ticks = data[DUR_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(op_t op, logic [LEVEL_W-1:0] level);
			lamp_status_t st;
			logic [LEVEL_W-1:0] avg;
			if (op == OP_SAMPLE) begin
				level_sum    = level_sum - ring[wr_ptr] + level;
				ring[wr_ptr] = level;
				wr_ptr       = (wr_ptr == IDX_LAST) ? '0 : wr_ptr + 1'b1;
				avg          = LEVEL_W'(level_sum / NUM_READINGS);
				if (avg < thresh) begin
					lamp       = 1'b1;
					hold_count = (on_ticks == '0) ? DUR_W'(1) : on_ticks;
				end
			end else begin
				if (hold_count != '0) begin
					hold_count--;
					if (hold_count == '0)
						lamp = 1'b0;
				end
				avg = LEVEL_W'(level_sum / NUM_READINGS);
			end
			st.lamp    = lamp;
			st.average = avg;
			status_q.push_back(st);
		endfunction

		function void check_result(logic [15:0] data);
			lamp_status_t want;
			if (status_q.size() == 0) begin
				fail($sformatf("unexpected status beat, tdata=%h", data));
				return;
			end
			want = status_q.pop_front();
			if (data[0] !== want.lamp)
				fail($sformatf("lamp_on: expected %0d, got %0d", want.lamp, data[0]));
			if (data[8:1] !== want.average)
				fail($sformatf("average_level: expected %0d, got %0d",
					want.average, data[8:1]));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;
	logic [0:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	lamp_scoreboard sb = new();
	bit             calm = 1'b0;
	int             stall_left = 0;
	bit             dark = 1'b0;

	always #5 clk = ~clk;

	moving_average_light_trigger i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Receiver side: ready drops in random bursts, never once the run calms down.
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			m_axis_tready <= arst_n;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	task automatic send_item(op_t op, logic [7:0] level);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= level;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(op, level);
	endtask

	task automatic send_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the input until every status beat is back, then let the pipeline settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_item();
		if ($urandom_range(0, 29) == 0)
			dark = !dark;
		send_gap();
		if ($urandom_range(0, 1) != 0)
			send_item(OP_TICK, 8'($urandom_range(0, 255)));
		else
			send_item(OP_SAMPLE, dark ? 8'($urandom_range(0, 60)) : 8'($urandom_range(0, 255)));
	endtask

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0]  thr;
		logic [15:0] dur;
		int          waited;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a tick with no countdown, then a dark ring that lights
		// the lamp, a few ticks, and a bright ring that leaves it counting down.
		send_item(OP_TICK, 8'hFF);
		repeat (8) send_item(OP_SAMPLE, 8'h00);
		repeat (3) send_item(OP_TICK, 8'($urandom_range(0, 255)));
		repeat (8) send_item(OP_SAMPLE, 8'hFF);
		send_item(OP_TICK, 8'hA5);
		wait_drained();

		// Upper data bits must be dropped, a zero duration acts as one tick,
		// and writes to unknown indexes change nothing.
		write_reg(REG_MIN_THRESHOLD, 16'hFFFF);
		write_reg(REG_ON_DURATION, 16'h0000);
		write_reg(8'hFF, 16'h0001);
		write_reg(CFG_IDX_W'(REG_ON_DURATION + 1), 16'h0005);
		send_item(OP_SAMPLE, 8'h5A);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin thr = 8'd0; dur = 16'd1; end
				1: begin thr = 8'd255; dur = 16'hFFFF; end
				6: begin thr = 8'($urandom_range(60, 200)); dur = 16'($urandom_range(0, 5)); end
				default: begin
					thr = 8'($urandom_range(60, 200));
					dur = 16'($urandom_range(1, 30));
				end
			endcase
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_ON_DURATION, {16'($urandom_range(0, 65535))} & 16'h0000 | dur);
				write_reg(REG_MIN_THRESHOLD, {8'($urandom_range(0, 255)), thr});
			end else begin
				write_reg(REG_MIN_THRESHOLD, {8'($urandom_range(0, 255)), thr});
				write_reg(REG_ON_DURATION, dur);
			end
			write_reg(8'($urandom_range(REG_ON_DURATION + 1, 255)), 16'($urandom_range(0, 65535)));
			if (ph == 6)
				calm = 1'b1;
			for (int n = 0; n < 250; n++) begin
				if (ph == 3 && n == 125)
					wait_drained();
				random_item();
			end
			wait_drained();
		end

		waited = 0;
		while (sb.pending() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.fail($sformatf("%0d status beats never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
